@@ hw/rtl/two_venue_spread_sampler_assert.svh @@
// ============================================================================
// Assertion macros for the two-venue spread sampler
// Shared property forms; each use names its label, terms and message.
// ============================================================================
`ifndef TWO_VENUE_SPREAD_SAMPLER_ASSERT_SVH
`define TWO_VENUE_SPREAD_SAMPLER_ASSERT_SVH

// Same-cycle implication, off while reset is asserted.
`define TVSS_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define TVSS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds across reset.
`define TVSS_ASSERT_NEXT_ALWAYS(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/tvss_pkg.sv @@
// ============================================================================
// Two-venue spread sampler package
// Widths, codes and payload types shared by the sampler modules.
// ============================================================================
package tvss_pkg;

    localparam int PRICE_BITS    = 40;
    localparam int FRAC_BITS     = 16;
    localparam int TIME_BITS     = 48;
    localparam int IVL_BITS      = 32;
    localparam int SPREAD_BITS   = 32;
    localparam int OP_BITS       = 2;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 48;

    localparam logic [OP_BITS-1:0] OP_QUOTE1 = 2'd0;
    localparam logic [OP_BITS-1:0] OP_QUOTE2 = 2'd1;
    localparam logic [OP_BITS-1:0] OP_TICK   = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_START = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_END   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IVL   = 2'd2;

    localparam logic [IVL_BITS-1:0] IVL_RESET = 32'd1000;

    // Divider sizing: |p - q| * 100 needs 7 more bits, then FRAC_BITS + 1
    // fraction bits (one extra for rounding).
    localparam int SCALE_BITS = PRICE_BITS + 7;
    localparam int DVD_BITS   = SCALE_BITS + FRAC_BITS + 1;
    localparam int STEP_BITS  = $clog2(DVD_BITS);
    localparam int QUO_BITS   = SPREAD_BITS + 2;
    localparam int MAG_BITS   = SPREAD_BITS + 1;

    localparam logic [MAG_BITS-1:0] MAG_POS_LIM =
        MAG_BITS'((64'd1 << (SPREAD_BITS - 1)) - 64'd1);
    localparam logic [MAG_BITS-1:0] MAG_NEG_LIM =
        MAG_BITS'(64'd1 << (SPREAD_BITS - 1));

    localparam int JOBQ_DEPTH    = 2;
    localparam int JOBQ_PTR_BITS = $clog2(JOBQ_DEPTH);
    localparam int JOBQ_CNT_BITS = $clog2(JOBQ_DEPTH + 1);

    typedef struct packed {
        logic [OP_BITS-1:0]    op;
        logic [PRICE_BITS-1:0] ask_price;
        logic [PRICE_BITS-1:0] bid_price;
    } t_item;

    typedef struct packed {
        logic [TIME_BITS-1:0]   bucket_time;
        logic [PRICE_BITS-1:0]  entry_buy_price;
        logic [PRICE_BITS-1:0]  entry_sell_price;
        logic [SPREAD_BITS-1:0] entry_spread;
        logic [PRICE_BITS-1:0]  exit_buy_price;
        logic [PRICE_BITS-1:0]  exit_sell_price;
        logic [SPREAD_BITS-1:0] exit_spread;
    } t_result;

    // One sampled bucket waiting for its spreads.
    typedef struct packed {
        logic [TIME_BITS-1:0]  bucket_time;
        logic [PRICE_BITS-1:0] ask1;
        logic [PRICE_BITS-1:0] bid1;
        logic [PRICE_BITS-1:0] ask2;
        logic [PRICE_BITS-1:0] bid2;
    } t_job;

endpackage

@@ hw/rtl/tvss_div.sv @@
// ============================================================================
// Spread divider
// Restoring divider, one quotient bit per cycle, giving (num/den - 1) * 100
// in signed fixed point with round half away from zero and saturation.
// ============================================================================
module tvss_div
    import tvss_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [PRICE_BITS-1:0]  i_num,
    input  logic [PRICE_BITS-1:0]  i_den,
    output logic                   o_done,
    output logic [SPREAD_BITS-1:0] o_spread
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCALE = 3'd1;
    localparam logic [2:0] S_RUN   = 3'd2;
    localparam logic [2:0] S_ROUND = 3'd3;
    localparam logic [2:0] S_SIGN  = 3'd4;

    logic [2:0]             r_state;
    logic [2:0]             n_state;
    logic                   r_done;
    logic                   r_neg;
    logic [PRICE_BITS-1:0]  r_diff;
    logic [PRICE_BITS-1:0]  r_den;
    logic [PRICE_BITS-1:0]  r_rem;
    logic [DVD_BITS-1:0]    r_dvd;
    logic [QUO_BITS-1:0]    r_q;
    logic                   r_ovf;
    logic [STEP_BITS-1:0]   r_step;
    logic [MAG_BITS-1:0]    r_mag;
    logic [SPREAD_BITS-1:0] r_res;

    logic [SCALE_BITS-1:0]  scaled;
    logic [PRICE_BITS:0]    trial;
    logic [PRICE_BITS:0]    trial_sub;
    logic                   ge;
    logic [QUO_BITS-1:0]    mag_sum;
    logic [MAG_BITS-1:0]    mag;
    logic [MAG_BITS-1:0]    limit;
    logic                   sat;
    logic [MAG_BITS-1:0]    neg_mag;

    always_comb begin
        // times 100 as 64 + 32 + 4
        scaled = (SCALE_BITS'(r_diff) << 6) + (SCALE_BITS'(r_diff) << 5)
               + (SCALE_BITS'(r_diff) << 2);
        trial     = {r_rem, r_dvd[DVD_BITS-1]};
        trial_sub = trial - {1'b0, r_den};
        ge        = trial >= {1'b0, r_den};
        mag_sum   = {1'b0, r_q[QUO_BITS-2:0]} + QUO_BITS'(1);
        mag       = mag_sum[QUO_BITS-1:1];
        limit     = r_neg ? MAG_NEG_LIM : MAG_POS_LIM;
        sat       = r_ovf | r_q[QUO_BITS-1];
        neg_mag   = MAG_BITS'(0) - r_mag;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_start) n_state = S_SCALE;
            S_SCALE: n_state = S_RUN;
            S_RUN:   if (r_step == '0) n_state = S_ROUND;
            S_ROUND: n_state = S_SIGN;
            S_SIGN:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_SIGN);
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    r_neg  <= i_num < i_den;
                    r_diff <= (i_num < i_den) ? i_den - i_num : i_num - i_den;
                    r_den  <= i_den;
                    r_rem  <= '0;
                    r_q    <= '0;
                    r_ovf  <= 1'b0;
                    r_step <= STEP_BITS'(DVD_BITS - 1);
                end
            end
            S_SCALE: begin
                r_dvd <= {scaled, {(FRAC_BITS + 1){1'b0}}};
            end
            S_RUN: begin
                r_rem  <= ge ? trial_sub[PRICE_BITS-1:0] : trial[PRICE_BITS-1:0];
                r_q    <= {r_q[QUO_BITS-2:0], ge};
                // any bit pushed out of the top means the result saturates
                r_ovf  <= r_ovf | r_q[QUO_BITS-1];
                r_dvd  <= {r_dvd[DVD_BITS-2:0], 1'b0};
                r_step <= r_step - STEP_BITS'(1);
            end
            S_ROUND: begin
                r_mag <= (sat || mag > limit) ? limit : mag;
            end
            S_SIGN: begin
                r_res <= r_neg ? neg_mag[SPREAD_BITS-1:0] : r_mag[SPREAD_BITS-1:0];
            end
            default: begin
            end
        endcase
    end

    assign o_done   = r_done;
    assign o_spread = r_res;

endmodule

@@ hw/rtl/tvss_front.sv @@
// ============================================================================
// Sampler front end
// Holds configuration and quotes, walks the bucket sequence on each tick and
// queues the buckets that yield a point.
// ============================================================================
module tvss_front
    import tvss_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                     i_push,
    input  t_item                    i_item,
    output logic                     o_full,
    output logic                     o_job_push,
    output t_job                     o_job,
    input  logic                     i_job_full
);

    localparam logic [1:0] F_IDLE  = 2'd0;
    localparam logic [1:0] F_CHECK = 2'd1;
    localparam logic [1:0] F_ADV   = 2'd2;

    logic [1:0]            r_state;
    logic [1:0]            n_state;
    logic [TIME_BITS-1:0]  r_start;
    logic [TIME_BITS-1:0]  r_end;
    logic [IVL_BITS-1:0]   r_ivl;
    logic [PRICE_BITS-1:0] r_ask [2];
    logic [PRICE_BITS-1:0] r_bid [2];
    logic [1:0]            r_have;
    logic [TIME_BITS-1:0]  r_offset;
    logic                  r_past_end;
    logic [TIME_BITS:0]    r_bucket;
    logic [TIME_BITS+1:0]  r_next_sum;
    logic [TIME_BITS:0]    r_next_off;

    logic accept;
    logic window_ok;
    logic bucket_late;
    logic emit;

    always_comb begin
        accept      = i_push && (r_state == F_IDLE);
        window_ok   = (r_start <= r_end) && (r_ivl != '0) && !r_past_end;
        bucket_late = r_bucket > {1'b0, r_end};
        emit        = r_have[0] && r_have[1] && (r_ask[0] != '0) && (r_bid[0] != '0)
                    && (r_ask[1] != '0) && (r_bid[1] != '0);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (accept && i_item.op == OP_TICK && window_ok) n_state = F_CHECK;
            end
            F_CHECK: begin
                if (bucket_late) n_state = F_IDLE;
                else if (!(emit && i_job_full)) n_state = F_ADV;
            end
            F_ADV:   n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= F_IDLE;
            r_start    <= '0;
            r_end      <= '0;
            r_ivl      <= IVL_RESET;
            r_ask[0]   <= '0;
            r_ask[1]   <= '0;
            r_bid[0]   <= '0;
            r_bid[1]   <= '0;
            r_have     <= '0;
            r_offset   <= '0;
            r_past_end <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_START: r_start <= i_cfg_data[TIME_BITS-1:0];
                    CFG_END:   r_end   <= i_cfg_data[TIME_BITS-1:0];
                    CFG_IVL:   r_ivl   <= i_cfg_data[IVL_BITS-1:0];
                    default: begin
                    end
                endcase
            end
            if (accept && (i_item.op == OP_QUOTE1 || i_item.op == OP_QUOTE2)) begin
                r_ask[i_item.op[0]]  <= i_item.ask_price;
                r_bid[i_item.op[0]]  <= i_item.bid_price;
                r_have[i_item.op[0]] <= 1'b1;
            end
            if (r_state == F_CHECK && bucket_late) begin
                r_past_end <= 1'b1;
            end
            if (r_state == F_ADV) begin
                // stop at the window end instead of advancing past it
                if (r_next_sum > {2'b0, r_end}) r_past_end <= 1'b1;
                else r_offset <= r_next_off[TIME_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE) begin
            r_bucket <= {1'b0, r_start} + {1'b0, r_offset};
        end
        if (r_state == F_CHECK) begin
            r_next_sum <= {1'b0, r_bucket} + (TIME_BITS + 2)'(r_ivl);
            r_next_off <= {1'b0, r_offset} + (TIME_BITS + 1)'(r_ivl);
        end
    end

    assign o_full     = (r_state != F_IDLE);
    assign o_job_push = (r_state == F_CHECK) && !bucket_late && emit && !i_job_full;

    always_comb begin
        o_job.bucket_time = r_bucket[TIME_BITS-1:0];
        o_job.ask1        = r_ask[0];
        o_job.bid1        = r_bid[0];
        o_job.ask2        = r_ask[1];
        o_job.bid2        = r_bid[1];
    end

endmodule

@@ hw/rtl/tvss_jobq.sv @@
// ============================================================================
// Bucket job queue
// Short first-in first-out queue between the front end and the spread unit.
// ============================================================================
module tvss_jobq
    import tvss_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_head
);

    t_job                     r_mem [JOBQ_DEPTH];
    logic [JOBQ_PTR_BITS-1:0] r_wr;
    logic [JOBQ_PTR_BITS-1:0] r_rd;
    logic [JOBQ_CNT_BITS-1:0] r_count;

    logic do_push;
    logic do_pop;

    always_comb begin
        do_push = i_push && (r_count != JOBQ_CNT_BITS'(JOBQ_DEPTH));
        do_pop  = i_pop && (r_count != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == JOBQ_PTR_BITS'(JOBQ_DEPTH - 1)) ? '0
                      : r_wr + JOBQ_PTR_BITS'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == JOBQ_PTR_BITS'(JOBQ_DEPTH - 1)) ? '0
                      : r_rd + JOBQ_PTR_BITS'(1);
            end
            if (do_push && !do_pop) r_count <= r_count + JOBQ_CNT_BITS'(1);
            else if (do_pop && !do_push) r_count <= r_count - JOBQ_CNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_job;
    end

    assign o_full  = (r_count == JOBQ_CNT_BITS'(JOBQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];

endmodule

@@ hw/rtl/tvss_back.sv @@
// ============================================================================
// Sampler back end
// Takes queued buckets, computes both spreads on two dividers in parallel and
// loads the finished point into the output register.
// ============================================================================
module tvss_back
    import tvss_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_job_empty,
    input  t_job    i_job,
    output logic    o_job_pop,
    output logic    o_empty,
    input  logic    i_pop,
    output t_result o_result
);

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_WAIT = 2'd1;
    localparam logic [1:0] B_OUT  = 2'd2;

    logic [1:0]             r_state;
    logic [1:0]             n_state;
    t_job                   r_job;
    logic                   r_out_valid;
    t_result                r_out;

    logic                   start;
    logic                   out_free;
    logic                   entry_done;
    logic                   exit_done;
    logic [SPREAD_BITS-1:0] entry_spread;
    logic [SPREAD_BITS-1:0] exit_spread;

    always_comb begin
        start    = (r_state == B_IDLE) && !i_job_empty;
        out_free = !r_out_valid || i_pop;
    end

    tvss_div u_entry_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_num    (i_job.bid2),
        .i_den    (i_job.ask1),
        .o_done   (entry_done),
        .o_spread (entry_spread)
    );

    tvss_div u_exit_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_num    (i_job.ask2),
        .i_den    (i_job.bid1),
        .o_done   (exit_done),
        .o_spread (exit_spread)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE:  if (start) n_state = B_WAIT;
            // both dividers run the same number of steps
            B_WAIT:  if (entry_done && exit_done) n_state = B_OUT;
            B_OUT:   if (out_free) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_OUT && out_free) r_out_valid <= 1'b1;
            else if (i_pop) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) r_job <= i_job;
        if (r_state == B_OUT && out_free) begin
            r_out.bucket_time      <= r_job.bucket_time;
            r_out.entry_buy_price  <= r_job.ask1;
            r_out.entry_sell_price <= r_job.bid2;
            r_out.entry_spread     <= entry_spread;
            r_out.exit_buy_price   <= r_job.ask2;
            r_out.exit_sell_price  <= r_job.bid1;
            r_out.exit_spread      <= exit_spread;
        end
    end

    assign o_job_pop = start;
    assign o_empty   = !r_out_valid;
    assign o_result  = r_out;

endmodule

@@ hw/rtl/two_venue_spread_sampler.sv @@
// ============================================================================
// Two-venue spread sampler
// Merges two venues' quotes with bucket ticks and emits sampled spread points.
//
// Channel   Direction  Handshake                   Payload
// items     in         push / full                 i_item   (t_item)
// points    out        empty / pop                 o_result (t_result)
// config    in         i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// Quotes leave the front end free; a tick holds it in its check/advance states.
// A tick that yields a point has both spreads computed in the back end by
// two 64-step restoring dividers that run side by side.
// A two-entry job queue and the output register let the front end keep taking
// items while points are computed or wait to be popped.
// Synchronous reset clears all control state; no clearing pass follows.
// ============================================================================
module two_venue_spread_sampler
    import tvss_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     push,
    output logic                     full,
    input  t_item                    i_item,
    output logic                     empty,
    input  logic                     pop,
    output t_result                  o_result,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    logic job_push;
    logic job_full;
    logic job_pop;
    logic job_empty;
    t_job job_in;
    t_job job_head;

    assign o_cfg_ready = 1'b1;

    tvss_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_push      (push),
        .i_item      (i_item),
        .o_full      (full),
        .o_job_push  (job_push),
        .o_job       (job_in),
        .i_job_full  (job_full)
    );

    tvss_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_empty (job_empty),
        .o_head  (job_head)
    );

    tvss_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (job_empty),
        .i_job       (job_head),
        .o_job_pop   (job_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_result    (o_result)
    );

endmodule

@@ hw/rtl/tvss_checker.sv @@
// ============================================================================
// Sampler port checker
// Watches the top-level ports for reset, hold and point sanity rules.
// ============================================================================
`include "two_venue_spread_sampler_assert.svh"

module tvss_checker
    import tvss_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    push,
    input logic    full,
    input t_item   i_item,
    input logic    empty,
    input logic    pop,
    input t_result o_result
);

    `TVSS_ASSERT_NEXT_ALWAYS(a_reset_empty, !i_rst_n, empty, "output not empty after reset")

    `TVSS_ASSERT_NEXT(a_point_held, !empty && !pop, !empty && $stable(o_result), "point changed while waiting")

    `TVSS_ASSERT_NEXT(a_quote_one_cycle, push && !full && i_item.op != OP_TICK, !full, "quote held the front end")

    `TVSS_ASSERT_SAME(a_prices_nonzero, !empty, o_result.entry_buy_price != '0 && o_result.entry_sell_price != '0 && o_result.exit_buy_price != '0 && o_result.exit_sell_price != '0, "point with a zero price")

    `TVSS_ASSERT_SAME(a_entry_sign, !empty && o_result.entry_sell_price > o_result.entry_buy_price, !o_result.entry_spread[SPREAD_BITS-1], "entry spread sign wrong")

endmodule

bind two_venue_spread_sampler tvss_checker u_checker (.*);

@@ bench/tb_two_venue_spread_sampler.sv @@
// ============================================================================
// Testbench for the two-venue spread sampler
// Drives merged quote/tick streams through a series of bucket windows, with
// random idling on both sides and one long output stall. A scoreboard class
// predicts every sampled point and compares each popped point field by field.
// ============================================================================
module tb_two_venue_spread_sampler;
    timeunit 1ns;
    timeprecision 1ps;

    import tvss_pkg::*;

    localparam logic [OP_BITS-1:0] OP_UNUSED    = 2'd3;
    localparam logic [63:0]        TIME_MAX     = (64'd1 << TIME_BITS) - 64'd1;
    localparam logic [63:0]        IVL_MAX      = (64'd1 << IVL_BITS) - 64'd1;
    localparam logic [PRICE_BITS-1:0] PRICE_MAX = '1;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int HOLD_CYCLES   = 3000;
    localparam int SETTLE_CYCLES = 200;
    localparam int TAIL_BUCKETS  = 20;

    // Predicts sampled points from accepted items and checks popped ones.
    class spread_scoreboard;
        logic [63:0]           win_start;
        logic [63:0]           win_end;
        logic [63:0]           win_ivl;
        logic [PRICE_BITS-1:0] held_ask [2];
        logic [PRICE_BITS-1:0] held_bid [2];
        bit                    have_quote [2];
        logic [63:0]           bucket_ofs;
        bit                    window_done;
        t_result               points_due [$];
        int                    errors;

        function new();
            win_start   = 64'd0;
            win_end     = 64'd0;
            win_ivl     = 64'(IVL_RESET);
            held_ask    = '{default: '0};
            held_bid    = '{default: '0};
            have_quote  = '{default: 1'b0};
            bucket_ofs  = 64'd0;
            window_done = 1'b0;
            errors      = 0;
        endfunction

        function void apply_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                CFG_START: win_start = 64'(data[TIME_BITS-1:0]);
                CFG_END:   win_end   = 64'(data[TIME_BITS-1:0]);
                CFG_IVL:   win_ivl   = 64'(data[IVL_BITS-1:0]);
                default: ;
            endcase
        endfunction

        // Percent spread of num over den in signed Q16, rounded half away from zero.
        function logic [SPREAD_BITS-1:0] spread_q16(logic [PRICE_BITS-1:0] num,
                                                    logic [PRICE_BITS-1:0] den);
            logic         neg;
            logic [127:0] scaled;
            logic [127:0] mag;
            logic [127:0] lim;
            neg    = num < den;
            scaled = neg ? 128'(den - num) : 128'(num - den);
            scaled = (scaled * 128'd100) << (FRAC_BITS + 1);
            mag    = ((scaled / 128'(den)) + 128'd1) >> 1;
            lim    = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
            if (mag > lim)
                mag = lim;
            return neg ? -mag[SPREAD_BITS-1:0] : mag[SPREAD_BITS-1:0];
        endfunction

        function void note_item(t_item it);
            t_result     pt;
            logic [63:0] bucket;
            logic [63:0] nxt;
            int          v;
            if (it.op == OP_QUOTE1 || it.op == OP_QUOTE2) begin
                v = (it.op == OP_QUOTE2) ? 1 : 0;
                held_ask[v]   = it.ask_price;
                held_bid[v]   = it.bid_price;
                have_quote[v] = 1'b1;
                return;
            end
            if (it.op != OP_TICK)
                return;
            if (win_start > win_end || win_ivl == 0 || window_done)
                return;
            bucket = win_start + bucket_ofs;
            if (bucket > win_end) begin
                window_done = 1'b1;
                return;
            end
            if (have_quote[0] && have_quote[1] && held_ask[0] != 0 && held_bid[0] != 0
                    && held_ask[1] != 0 && held_bid[1] != 0) begin
                pt.bucket_time      = bucket[TIME_BITS-1:0];
                pt.entry_buy_price  = held_ask[0];
                pt.entry_sell_price = held_bid[1];
                pt.entry_spread     = spread_q16(held_bid[1], held_ask[0]);
                pt.exit_buy_price   = held_ask[1];
                pt.exit_sell_price  = held_bid[0];
                pt.exit_spread      = spread_q16(held_ask[1], held_bid[0]);
                points_due = {points_due, pt};
            end
            // Stop at the last bucket instead of running past the window end.
            nxt = bucket_ofs + win_ivl;
            if (win_start + nxt > win_end)
                window_done = 1'b1;
            else
                bucket_ofs = nxt;
        endfunction

        function void cmp(string field, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $error("%s: expected %0h, got %0h", field, want, got);
                errors++;
            end
        endfunction

        function void check_point(t_result got);
            t_result want;
            if (points_due.size() == 0) begin
                $error("bucket_time: expected no point, got %0h", got.bucket_time);
                errors++;
                return;
            end
            want = points_due.pop_front();
            cmp("bucket_time",      64'(want.bucket_time),      64'(got.bucket_time));
            cmp("entry_buy_price",  64'(want.entry_buy_price),  64'(got.entry_buy_price));
            cmp("entry_sell_price", 64'(want.entry_sell_price), 64'(got.entry_sell_price));
            cmp("entry_spread",     64'(want.entry_spread),     64'(got.entry_spread));
            cmp("exit_buy_price",   64'(want.exit_buy_price),   64'(got.exit_buy_price));
            cmp("exit_sell_price",  64'(want.exit_sell_price),  64'(got.exit_sell_price));
            cmp("exit_spread",      64'(want.exit_spread),      64'(got.exit_spread));
        endfunction
    endclass

    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     push        = 1'b0;
    logic                     full;
    t_item                    i_item      = '0;
    logic                     empty;
    logic                     pop         = 1'b0;
    t_result                  o_result;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data  = '0;

    spread_scoreboard sb;
    bit               fast_mode = 1'b0;
    bit               hold_req  = 1'b0;
    int               cycle_cnt = 0;

    two_venue_spread_sampler uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("[two_venue_spread_sampler] ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                sb.apply_reg(i_cfg_index, i_cfg_data);
            if (push && !full)
                sb.note_item(i_item);
            if (pop && !empty)
                sb.check_point(o_result);
        end
    end

    // Point side: random stalls, plus one long hold-off on request.
    initial begin : pop_side
        int stall;
        int held;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                pop <= 1'b0;
                held = 0;
                while (held < HOLD_CYCLES) begin
                    @(posedge i_clk);
                    held++;
                end
            end else begin
                stall = fast_mode ? 0 : $urandom_range(0, 4);
                if (stall != 0) begin
                    pop <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
        end
    end

    function automatic logic [PRICE_BITS-1:0] rand_price();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[PRICE_BITS-1:0];
    endfunction

    function automatic logic [PRICE_BITS-1:0] pick_base();
        logic [PRICE_BITS-1:0] b;
        b = rand_price() >> $urandom_range(0, PRICE_BITS - 1);
        return (b == 0) ? PRICE_BITS'(1) : b;
    endfunction

    task automatic send_item(input logic [OP_BITS-1:0] op, input logic [PRICE_BITS-1:0] ask,
                             input logic [PRICE_BITS-1:0] bid);
        int    gap;
        t_item it;
        gap          = fast_mode ? 0 : $urandom_range(0, 4);
        it.op        = op;
        it.ask_price = ask;
        it.bid_price = bid;
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic set_window(input logic [CFG_DATA_BITS-1:0] t0, input logic [CFG_DATA_BITS-1:0] t1,
                              input logic [CFG_DATA_BITS-1:0] ivl);
        write_reg(CFG_START, t0);
        write_reg(CFG_END, t1);
        write_reg(CFG_IVL, ivl);
        i_cfg_valid <= 1'b0;
    endtask

    // Drop push, wait for every pending point, then let a silent tick finish.
    task automatic settle();
        push <= 1'b0;
        while (sb.points_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Mostly quotes near a drifting price level followed by ticks; some wide
    // prices, zero prices and unused op codes as noise.
    task automatic run_random(input int n_items);
        int                    sent;
        int                    pick;
        logic [PRICE_BITS-1:0] base;
        logic [PRICE_BITS-1:0] a;
        logic [PRICE_BITS-1:0] b;
        logic [PRICE_BITS-1:0] d;
        logic [OP_BITS-1:0]    op;
        sent = 0;
        base = pick_base();
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 15) == 0)
                base = pick_base();
            op = ($urandom_range(0, 1) != 0) ? OP_QUOTE2 : OP_QUOTE1;
            d  = (base >> $urandom_range(1, 12)) & rand_price();
            a  = base + d;
            d  = (base >> $urandom_range(1, 12)) & rand_price();
            b  = base - d;
            if (pick < 30) begin
                op = OP_TICK;
                a  = rand_price();
                b  = rand_price();
            end else if (pick >= 94) begin
                op = OP_UNUSED;
                a  = rand_price();
                b  = rand_price();
            end else if (pick >= 88) begin
                case ($urandom_range(0, 2))
                    0: a = '0;
                    1: b = '0;
                    default: begin
                        a = '0;
                        b = '0;
                    end
                endcase
            end else if (pick >= 80) begin
                a = rand_price();
                b = rand_price();
            end
            send_item(op, a, b);
            if (op != OP_UNUSED)
                sent++;
        end
    endtask

    initial begin : stimulus
        logic [63:0] tail_ivl;
        logic [63:0] tail_start;
        logic [63:0] mid_start;
        logic [63:0] mid_ivl;
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Unit spacing from time zero with an open-ended window.
        set_window(64'd0, TIME_MAX, 64'd1);
        send_item(OP_UNUSED, PRICE_MAX, PRICE_MAX);
        send_item(OP_TICK, '0, '0);                 // no quotes held yet
        send_item(OP_QUOTE1, PRICE_MAX, 40'd1);
        send_item(OP_TICK, PRICE_MAX, PRICE_MAX);   // venue two still missing
        send_item(OP_QUOTE2, 40'd1, PRICE_MAX);
        send_item(OP_TICK, '0, '0);
        send_item(OP_QUOTE1, 40'd1, PRICE_MAX);
        send_item(OP_QUOTE2, PRICE_MAX, PRICE_MAX);
        send_item(OP_TICK, '0, '0);                 // entry spread saturates
        send_item(OP_QUOTE2, 40'd1, 40'd1);
        send_item(OP_TICK, '0, '0);                 // exit spread near minus 100
        send_item(OP_QUOTE1, '0, 40'd5);
        send_item(OP_TICK, '0, '0);
        send_item(OP_QUOTE1, 40'd5, '0);
        send_item(OP_TICK, '0, '0);
        send_item(OP_QUOTE1, 40'd13107200, 40'd13107200);
        send_item(OP_QUOTE2, 40'd13107199, 40'd13107201);
        send_item(OP_TICK, '0, '0);                 // half-LSB ties, both signs
        send_item(OP_QUOTE2, '0, 40'd7);
        send_item(OP_TICK, '0, '0);
        send_item(OP_QUOTE2, 40'd4, 40'd2);
        send_item(OP_QUOTE1, 40'd3, 40'd8);
        send_item(OP_TICK, '0, '0);
        run_random(250);
        settle();

        // Zero spacing: ticks sample nothing and hold the bucket.
        set_window(64'd0, TIME_MAX, 64'd0);
        run_random(80);
        settle();

        // Start after end: nothing sampled.
        set_window(64'd5000, 64'd0, IVL_MAX);
        run_random(80);
        settle();

        set_window(64'd1 << 47, TIME_MAX, IVL_MAX);
        fast_mode = 1'b1;
        run_random(150);
        fast_mode = 1'b0;
        run_random(150);
        settle();

        mid_start = 64'(rand_price());
        mid_ivl   = 64'($urandom_range(1, 100000));
        set_window(mid_start, TIME_MAX, mid_ivl);
        hold_req = 1'b1;
        run_random(150);
        run_random(550);
        settle();

        // Last buckets land exactly on the top of the time range; later
        // ticks find the window used up.
        tail_ivl   = 64'($urandom_range(1, 1 << 20));
        tail_start = TIME_MAX - sb.bucket_ofs - TAIL_BUCKETS * tail_ivl;
        set_window(tail_start, TIME_MAX, tail_ivl);
        run_random(100);
        settle();

        if (sb.errors == 0 && sb.points_due.size() == 0)
            $display("[two_venue_spread_sampler] OK");
        else
            $display("[two_venue_spread_sampler] ERROR");
        $finish;
    end

endmodule
